// ===== sv/assert_macros.svh =====
// assertion macros shared by the encoder modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge outside reset
`define SFE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every rising edge, reset included
`define SFE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/sfe_pkg.sv =====
// shared types, constants and functions of the segment frame encoder
package sfe_pkg;

    localparam int VALUE_W  = 14;
    localparam int BCD_W    = 16;
    localparam int Q_DEPTH  = 2;
    localparam int Q_AW     = $clog2(Q_DEPTH);
    localparam int Q_CW     = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] ADDR_CONTROL   = 8'h48;
    localparam logic [7:0] ADDR_THOUSANDS = 8'h6C;
    localparam logic [7:0] ADDR_HUNDREDS  = 8'h6A;
    localparam logic [7:0] ADDR_TENS      = 8'h68;
    localparam logic [7:0] ADDR_ONES      = 8'h6E;

    localparam logic [3:0] CTRL_LOW_BITS  = 4'h5;
    localparam logic [1:0] FRAME_LAST     = 2'd3;
    localparam logic       MODE_CONTROL   = 1'b0;
    localparam logic       MODE_NUMBER    = 1'b1;
    localparam logic [2:0] BRIGHT_RESET   = 3'd1;

    // address by frame position within a number item
    localparam logic [3:0][7:0] DIGIT_ADDR = {
        ADDR_ONES, ADDR_TENS, ADDR_HUNDREDS, ADDR_THOUSANDS
    };

    typedef struct packed {
        logic                 mode;
        logic [VALUE_W-1:0]   value;
    } t_in;

    typedef struct packed {
        logic [7:0] address_byte;
        logic [7:0] data_byte;
        logic       last;
    } t_out;

    // digits[3] is thousands, digits[0] ones
    typedef struct packed {
        logic            mode;
        logic [3:0][3:0] digits;
    } t_job;

    function automatic logic [7:0] seg_pattern(input logic [3:0] d);
        logic [7:0] p;
        case (d)
            4'd0:    p = 8'hF5;
            4'd1:    p = 8'h84;
            4'd2:    p = 8'hB3;
            4'd3:    p = 8'h97;
            4'd4:    p = 8'hC6;
            4'd5:    p = 8'h57;
            4'd6:    p = 8'h77;
            4'd7:    p = 8'h85;
            4'd8:    p = 8'hF7;
            4'd9:    p = 8'hD7;
            default: p = 8'h00;
        endcase
        return p;
    endfunction

    // one double-dabble step, carry out of the top digit is dropped
    function automatic logic [BCD_W-1:0] dd_step(input logic [BCD_W-1:0] b,
                                                 input logic bit_in);
        logic [BCD_W-1:0] a;
        a = b;
        for (int i = 0; i < BCD_W / 4; i++) begin
            if (a[i*4 +: 4] >= 4'd5) begin
                a[i*4 +: 4] = a[i*4 +: 4] + 4'd3;
            end
        end
        return {a[BCD_W-2:0], bit_in};
    endfunction

    // four steps, msb of bits_in first
    function automatic logic [BCD_W-1:0] dd_step4(input logic [BCD_W-1:0] b,
                                                  input logic [3:0] bits_in);
        logic [BCD_W-1:0] a;
        a = b;
        for (int i = 3; i >= 0; i--) begin
            a = dd_step(a, bits_in[i]);
        end
        return a;
    endfunction

endpackage

// ===== sv/four_digit_segment_frame_encoder.sv =====
// top level of the four-digit segment frame encoder
//
//  channel   direction  handshake                     payload
//  in        input      i_in_valid / o_in_ready       i_in   (mode, value)
//  out       output     o_out_valid / i_out_ready     o_out  (address_byte, data_byte, last)
//  cfg       input      i_cfg_valid / o_cfg_ready     i_cfg_data (brightness)
//
// a number item runs through the converter at four double-dabble steps a cycle over 16 bits
// a control item skips the conversion steps; the frame stage sends one frame a cycle while the output is ready
// the converter takes a new item only as the last one passes into the queue; a number item also needs four frames
// reset is synchronous: queue empty, no frame pending, brightness 1
// a two-entry queue parts converter and frame stage, so each stalls on its own
module four_digit_segment_frame_encoder (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  sfe_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output sfe_pkg::t_out o_out,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [2:0]    i_cfg_data
);

    logic          w_push_valid, w_push_ready, w_head_valid, w_pop;
    sfe_pkg::t_job w_push_job, w_head_job;

    assign o_cfg_ready = 1'b1;

    sfe_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_ready      (o_in_ready),
        .i_item       (i_in),
        .o_push_valid (w_push_valid),
        .i_push_ready (w_push_ready),
        .o_push_job   (w_push_job)
    );

    sfe_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_job   (w_push_job),
        .o_head_valid (w_head_valid),
        .i_pop        (w_pop),
        .o_head_job   (w_head_job)
    );

    sfe_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_head_valid (w_head_valid),
        .i_head_job   (w_head_job),
        .o_pop        (w_pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out        (o_out)
    );

endmodule

// ===== sv/sfe_front.sv =====
// front end: accepts items and converts the value to decimal digits
`include "assert_macros.svh"

module sfe_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  sfe_pkg::t_in  i_item,
    output logic          o_push_valid,
    input  logic          i_push_ready,
    output sfe_pkg::t_job o_push_job
);

    typedef enum logic [2:0] {
        FS_IDLE = 3'b001,
        FS_CONV = 3'b010,
        FS_DONE = 3'b100
    } t_fstate;

    t_fstate r_state, n_state;
    logic [1:0] r_cnt, n_cnt;
    logic [11:0] r_sh, n_sh;
    logic [sfe_pkg::BCD_W-1:0] r_bcd, n_bcd;
    logic r_mode, n_mode;

    logic w_accept;
    logic [sfe_pkg::BCD_W-1:0] w_v16;

    assign w_v16        = {2'b00, i_item.value};
    assign o_ready      = (r_state == FS_IDLE) || ((r_state == FS_DONE) && i_push_ready);
    assign w_accept     = i_valid && o_ready;
    assign o_push_valid = (r_state == FS_DONE);
    assign o_push_job   = '{mode: r_mode, digits: r_bcd};

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_sh    = r_sh;
        n_bcd   = r_bcd;
        n_mode  = r_mode;
        unique case (r_state)
            FS_IDLE, FS_DONE: begin
                if ((r_state == FS_DONE) && i_push_ready) begin
                    n_state = FS_IDLE;
                end
                if (w_accept) begin
                    n_mode = i_item.mode;
                    n_cnt  = 2'd0;
                    n_sh   = w_v16[11:0];
                    n_bcd  = sfe_pkg::dd_step4('0, w_v16[15:12]);
                    if (i_item.mode == sfe_pkg::MODE_NUMBER) begin
                        n_state = FS_CONV;
                    end else begin
                        n_state = FS_DONE;
                    end
                end
            end
            FS_CONV: begin
                n_bcd = sfe_pkg::dd_step4(r_bcd, r_sh[11:8]);
                n_sh  = {r_sh[7:0], 4'b0000};
                n_cnt = r_cnt + 2'd1;
                if (r_cnt == 2'd2) begin
                    n_state = FS_DONE;
                end
            end
            default: n_state = FS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_IDLE;
            r_cnt   <= 2'd0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
        r_sh   <= n_sh;
        r_bcd  <= n_bcd;
        r_mode <= n_mode;
    end

    `SFE_ASSERT(a_number_converts, i_clk, i_rst_n, (w_accept && i_item.mode) |=> (r_state == FS_CONV), "number item did not enter conversion")
    `SFE_ASSERT(a_control_done, i_clk, i_rst_n, (w_accept && !i_item.mode) |=> o_push_valid, "control item not offered to queue")
    `SFE_ASSERT(a_conv_bound, i_clk, i_rst_n, (r_state == FS_CONV) |-> (r_cnt != 2'd3), "conversion ran too long")

endmodule

// ===== sv/sfe_fifo.sv =====
// small queue of converted items between front and back
`include "assert_macros.svh"

module sfe_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    output logic          o_push_ready,
    input  sfe_pkg::t_job i_push_job,
    output logic          o_head_valid,
    input  logic          i_pop,
    output sfe_pkg::t_job o_head_job
);

    sfe_pkg::t_job r_mem [sfe_pkg::Q_DEPTH];
    logic [sfe_pkg::Q_AW-1:0] r_wptr, r_rptr;
    logic [sfe_pkg::Q_CW-1:0] r_count;

    logic w_push, w_pop;

    assign o_push_ready = (r_count != sfe_pkg::Q_CW'(sfe_pkg::Q_DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head_job   = r_mem[r_rptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = i_pop && o_head_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= (r_wptr == sfe_pkg::Q_AW'(sfe_pkg::Q_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= (r_rptr == sfe_pkg::Q_AW'(sfe_pkg::Q_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            r_count <= r_count + sfe_pkg::Q_CW'(w_push) - sfe_pkg::Q_CW'(w_pop);
        end
        if (w_push) begin
            r_mem[r_wptr] <= i_push_job;
        end
    end

    `SFE_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= sfe_pkg::Q_CW'(sfe_pkg::Q_DEPTH), "queue count beyond depth")
    `SFE_ASSERT(a_pop_nonempty, i_clk, i_rst_n, i_pop |-> o_head_valid, "pop from empty queue")
    `SFE_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_head_valid, "queue not empty after reset")

endmodule

// ===== sv/sfe_back.sv =====
// back end: turns queued items into bus frames behind an output register
`include "assert_macros.svh"

module sfe_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_valid,
    input  logic [2:0]    i_cfg_data,
    input  logic          i_head_valid,
    input  sfe_pkg::t_job i_head_job,
    output logic          o_pop,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output sfe_pkg::t_out o_out
);

    logic          r_ov;
    sfe_pkg::t_out r_out, n_out;
    logic [1:0]    r_idx;
    logic [2:0]    r_bright;

    logic w_load, w_take, w_is_ctrl;
    logic [3:0] w_digit;

    assign w_load    = !r_ov || i_out_ready;
    assign w_take    = w_load && i_head_valid;
    assign w_is_ctrl = (i_head_job.mode == sfe_pkg::MODE_CONTROL);
    assign w_digit   = i_head_job.digits[~r_idx];
    assign o_pop     = w_take && (w_is_ctrl || (r_idx == sfe_pkg::FRAME_LAST));
    assign o_out_valid = r_ov;
    assign o_out     = r_out;

    always_comb begin
        if (w_is_ctrl) begin
            n_out = '{address_byte: sfe_pkg::ADDR_CONTROL,
                      data_byte:    {1'b0, r_bright, sfe_pkg::CTRL_LOW_BITS},
                      last:         1'b1};
        end else begin
            n_out = '{address_byte: sfe_pkg::DIGIT_ADDR[r_idx],
                      data_byte:    sfe_pkg::seg_pattern(w_digit),
                      last:         (r_idx == sfe_pkg::FRAME_LAST)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov     <= 1'b0;
            r_idx    <= 2'd0;
            r_bright <= sfe_pkg::BRIGHT_RESET;
        end else begin
            if (i_cfg_valid) begin
                r_bright <= i_cfg_data;
            end
            if (w_load) begin
                r_ov <= i_head_valid;
            end
            if (w_take && !w_is_ctrl) begin
                r_idx <= r_idx + 2'd1;
            end
        end
        if (w_take) begin
            r_out <= n_out;
        end
    end

    `SFE_ASSERT(a_mid_item_held, i_clk, i_rst_n, (r_idx != 2'd0) |-> (i_head_valid && !w_is_ctrl), "number item left queue mid frame run")
    `SFE_ASSERT(a_pop_on_last, i_clk, i_rst_n, o_pop |=> (r_ov && r_out.last), "item popped without last frame")
    `SFE_ASSERT(a_out_hold, i_clk, i_rst_n, (r_ov && !i_out_ready) |=> (r_ov && $stable(r_out)), "stalled frame changed")

endmodule
